// ===== design/batb_pkg.sv =====
`default_nettype none
package batb_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int COEF_WIDTH    = 16;
  localparam int FRAC_BITS     = COEF_WIDTH - 2;
  localparam int ROW_WIDTH     = 3 * COEF_WIDTH;
  localparam int PROD_WIDTH    = COORD_WIDTH + COEF_WIDTH;
  localparam int SUM_WIDTH     = PROD_WIDTH + 2;
  localparam int SHR_WIDTH     = SUM_WIDTH - FRAC_BITS;
  localparam int CFG_WIDTH     = (ROW_WIDTH > COORD_WIDTH) ? ROW_WIDTH : COORD_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int QUEUE_AW      = 2;
  localparam int QUEUE_DEPTH   = 1 << QUEUE_AW;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic signed [SHR_WIDTH-1:0]   shr_t;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    coord_t lo_x;
    coord_t lo_y;
    coord_t lo_z;
    coord_t hi_x;
    coord_t hi_y;
    coord_t hi_z;
  } box_t;

  typedef struct packed {
    coord_t out_lo_x;
    coord_t out_lo_y;
    coord_t out_lo_z;
    coord_t out_hi_x;
    coord_t out_hi_y;
    coord_t out_hi_z;
    logic   clipped;
  } res_t;

  // coef[r][k]: output axis r, input axis k
  typedef struct packed {
    coef_t  [2:0][2:0] coef;
    coord_t [2:0]      shift;
  } xform_t;

  typedef struct packed {
    prod_t [2:0][2:0] lo;
    prod_t [2:0][2:0] hi;
  } prod_set_t;

  typedef struct packed {
    logic   clip;
    coord_t value;
  } sat_t;

  function automatic sat_t saturate(input shr_t v);
    sat_t r;
    logic [SHR_WIDTH-COORD_WIDTH:0] top;
    top = v[SHR_WIDTH-1:COORD_WIDTH-1];
    if ((&top) || !(|top)) begin
      r.clip  = 1'b0;
      r.value = v[COORD_WIDTH-1:0];
    end else begin
      r.clip  = 1'b1;
      r.value = v[SHR_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                               : {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/batb_queue.sv =====
`default_nettype none
module batb_queue
  import batb_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  box_t in_data,
  output logic out_valid,
  input  wire  out_stall,
  output box_t out_data
);

  box_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]   count_r, count_nxt;
  logic                push, pop;

  assign in_stall  = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= in_data;
    end
  end

endmodule
`default_nettype wire

// ===== design/batb_prod.sv =====
`default_nettype none
module batb_prod
  import batb_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  box_t      in_data,
  input  xform_t    xf,
  output logic      out_valid,
  input  wire       out_stall,
  output prod_set_t out_data
);

  logic      valid_r;
  prod_set_t prod_r, prod_nxt;
  coord_t    lo_v [3];
  coord_t    hi_v [3];
  logic      adv;

  assign adv       = !valid_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = valid_r;
  assign out_data  = prod_r;

  always_comb begin
    lo_v[0] = in_data.lo_x;
    lo_v[1] = in_data.lo_y;
    lo_v[2] = in_data.lo_z;
    hi_v[0] = in_data.hi_x;
    hi_v[1] = in_data.hi_y;
    hi_v[2] = in_data.hi_z;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt.lo[r][k] = prod_t'($signed(lo_v[k])) * prod_t'($signed(xf.coef[r][k]));
        prod_nxt.hi[r][k] = prod_t'($signed(hi_v[k])) * prod_t'($signed(xf.coef[r][k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/batb_reduce.sv =====
`default_nettype none
module batb_reduce
  import batb_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_stall,
  input  prod_set_t in_data,
  input  xform_t    xf,
  output logic      out_valid,
  input  wire       out_stall,
  output res_t      out_data
);

  // select stage
  logic  sel_v_r;
  prod_t mn_r [3][3];
  prod_t mx_r [3][3];
  // partial sum stage
  logic  add_v_r;
  sum_t  mn_a_r [3], mn_b_r [3];
  sum_t  mx_a_r [3], mx_b_r [3];
  // output stage
  logic  out_v_r;
  res_t  res_r, res_nxt;

  logic  adv_out, adv_add, adv_sel;
  sum_t  base [3];
  sum_t  tot_mn, tot_mx;
  sat_t  s_mn [3];
  sat_t  s_mx [3];

  assign adv_out   = !out_v_r || !out_stall;
  assign adv_add   = !add_v_r || adv_out;
  assign adv_sel   = !sel_v_r || adv_add;
  assign in_stall  = !adv_sel;
  assign out_valid = out_v_r;
  assign out_data  = res_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      base[r] = {{(SUM_WIDTH-COORD_WIDTH-FRAC_BITS){xf.shift[r][COORD_WIDTH-1]}},
                 xf.shift[r], {FRAC_BITS{1'b0}}};
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      tot_mn  = mn_a_r[r] + mn_b_r[r];
      tot_mx  = mx_a_r[r] + mx_b_r[r];
      s_mn[r] = saturate(tot_mn[SUM_WIDTH-1:FRAC_BITS]);
      s_mx[r] = saturate(tot_mx[SUM_WIDTH-1:FRAC_BITS]);
    end
    res_nxt.out_lo_x = s_mn[0].value;
    res_nxt.out_lo_y = s_mn[1].value;
    res_nxt.out_lo_z = s_mn[2].value;
    res_nxt.out_hi_x = s_mx[0].value;
    res_nxt.out_hi_y = s_mx[1].value;
    res_nxt.out_hi_z = s_mx[2].value;
    res_nxt.clipped  = s_mn[0].clip || s_mn[1].clip || s_mn[2].clip ||
                       s_mx[0].clip || s_mx[1].clip || s_mx[2].clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r <= 1'b0;
      add_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv_sel) begin
        sel_v_r <= in_valid;
      end
      if (adv_add) begin
        add_v_r <= sel_v_r;
      end
      if (adv_out) begin
        out_v_r <= add_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_sel && in_valid) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          if ($signed(in_data.hi[r][k]) < $signed(in_data.lo[r][k])) begin
            mn_r[r][k] <= in_data.hi[r][k];
            mx_r[r][k] <= in_data.lo[r][k];
          end else begin
            mn_r[r][k] <= in_data.lo[r][k];
            mx_r[r][k] <= in_data.hi[r][k];
          end
        end
      end
    end
    if (adv_add && sel_v_r) begin
      for (int r = 0; r < 3; r++) begin
        mn_a_r[r] <= sum_t'(mn_r[r][0]) + sum_t'(mn_r[r][1]);
        mn_b_r[r] <= sum_t'(mn_r[r][2]) + base[r];
        mx_a_r[r] <= sum_t'(mx_r[r][0]) + sum_t'(mx_r[r][1]);
        mx_b_r[r] <= sum_t'(mx_r[r][2]) + base[r];
      end
    end
    if (adv_out && add_v_r) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/box_affine_transform_bounds.sv =====
`default_nettype none
// Bounds an axis-aligned box (Q16.16 min/max corners) after the affine transform
// p' = M*p + t, with M in signed Q2.14 and t in Q16.16, both set through the
// cfg_ port (index 0..2: coefficient rows x, y, z; 3..5: translation x, y, z;
// other indexes are ignored). The block takes one box every cycle when nothing
// is stalled; a box passes the queue, product register and select, partial sum
// and output stages. A 4-entry input queue lets requests keep coming while
// results are held back, and 18 parallel 32x16 multipliers set the one-per-cycle
// rate. Results round toward minus infinity and saturate to 32 bits, with clipped
// flagging it. Change the configuration only while no request is in flight.
module box_affine_transform_bounds
  import batb_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire [CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire [CFG_WIDTH-1:0]     cfg_wdata,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  box_t                    in_data,
  output logic                    out_valid,
  input  wire                     out_stall,
  output res_t                    out_data
);

  logic [ROW_WIDTH-1:0] row_r [3];
  coord_t               shift_r [3];
  xform_t               xf;

  logic      q_valid, q_stall;
  box_t      q_data;
  logic      p_valid, p_stall;
  prod_set_t p_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 3; r++) begin
        row_r[r]   <= ROW_WIDTH'(1) << (FRAC_BITS + r * COEF_WIDTH);
        shift_r[r] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROW_X:   row_r[0]   <= cfg_wdata[ROW_WIDTH-1:0];
        REG_ROW_Y:   row_r[1]   <= cfg_wdata[ROW_WIDTH-1:0];
        REG_ROW_Z:   row_r[2]   <= cfg_wdata[ROW_WIDTH-1:0];
        REG_SHIFT_X: shift_r[0] <= cfg_wdata[COORD_WIDTH-1:0];
        REG_SHIFT_Y: shift_r[1] <= cfg_wdata[COORD_WIDTH-1:0];
        REG_SHIFT_Z: shift_r[2] <= cfg_wdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        xf.coef[r][k] = row_r[r][k*COEF_WIDTH +: COEF_WIDTH];
      end
      xf.shift[r] = shift_r[r];
    end
  end

  batb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_data  (q_data)
  );

  batb_prod u_prod (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_stall  (q_stall),
    .in_data   (q_data),
    .xf        (xf),
    .out_valid (p_valid),
    .out_stall (p_stall),
    .out_data  (p_data)
  );

  batb_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_stall  (p_stall),
    .in_data   (p_data),
    .xf        (xf),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
